### rtl/core/present128_block_cipher_macros.svh
// Assertion helpers shared by the cipher RTL.
`ifndef PRESENT128_BLOCK_CIPHER_MACROS_SVH
`define PRESENT128_BLOCK_CIPHER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define P128_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("p128 assertion failed");

// Check a property on every clock edge, reset included.
`define P128_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("p128 assertion failed");

`endif

### rtl/core/p128_pkg.sv
package p128_pkg;

  localparam int unsigned BLOCK_W   = 64;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] KEY_HIGH_IDX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_LOW_IDX  = 8'd1;

  typedef struct packed {
    logic [BLOCK_W-1:0] hi;
    logic [BLOCK_W-1:0] lo;
  } key128_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'hC;
      4'h1: r = 4'h5;
      4'h2: r = 4'h6;
      4'h3: r = 4'hB;
      4'h4: r = 4'h9;
      4'h5: r = 4'h0;
      4'h6: r = 4'hA;
      4'h7: r = 4'hD;
      4'h8: r = 4'h3;
      4'h9: r = 4'hE;
      4'hA: r = 4'hF;
      4'hB: r = 4'h8;
      4'hC: r = 4'h4;
      4'hD: r = 4'h7;
      4'hE: r = 4'h1;
      default: r = 4'h2;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] n);
    logic [3:0] r;
    case (n)
      4'h0: r = 4'h5;
      4'h1: r = 4'hE;
      4'h2: r = 4'hF;
      4'h3: r = 4'h8;
      4'h4: r = 4'hC;
      4'h5: r = 4'h1;
      4'h6: r = 4'h2;
      4'h7: r = 4'hD;
      4'h8: r = 4'hB;
      4'h9: r = 4'h4;
      4'hA: r = 4'h6;
      4'hB: r = 4'h3;
      4'hC: r = 4'h0;
      4'hD: r = 4'h7;
      4'hE: r = 4'h9;
      default: r = 4'hA;
    endcase
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    for (int p = 0; p < BLOCK_W / 4; p++) begin
      r[4*p +: 4] = sbox_fwd(v[4*p +: 4]);
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    for (int p = 0; p < BLOCK_W / 4; p++) begin
      r[4*p +: 4] = sbox_inv(v[4*p +: 4]);
    end
    return r;
  endfunction

  // Bit i moves to 16*(i mod 4) + i/4.
  function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    for (int i = 0; i < BLOCK_W; i++) begin
      r[16*(i%4) + i/4] = v[i];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] v);
    logic [BLOCK_W-1:0] r;
    for (int i = 0; i < BLOCK_W; i++) begin
      r[4*(i%16) + i/16] = v[i];
    end
    return r;
  endfunction

  // One step of the 128-bit key schedule, and its exact inverse.
  function automatic key128_t key_step_fwd(input key128_t k, input logic [4:0] cnt);
    key128_t r;
    r.hi = {k.hi[2:0], k.lo[63:3]};
    r.lo = {k.lo[2:0], k.hi[63:3]};
    r.hi[63:60] = sbox_fwd(r.hi[63:60]);
    r.hi[59:56] = sbox_fwd(r.hi[59:56]);
    r.hi[2:0]   = r.hi[2:0] ^ cnt[4:2];
    r.lo[63:62] = r.lo[63:62] ^ cnt[1:0];
    return r;
  endfunction

  function automatic key128_t key_step_inv(input key128_t k, input logic [4:0] cnt);
    key128_t t;
    key128_t r;
    t = k;
    t.hi[2:0]   = t.hi[2:0] ^ cnt[4:2];
    t.lo[63:62] = t.lo[63:62] ^ cnt[1:0];
    t.hi[63:60] = sbox_inv(t.hi[63:60]);
    t.hi[59:56] = sbox_inv(t.hi[59:56]);
    r.hi = {t.lo[60:0], t.hi[63:61]};
    r.lo = {t.hi[60:0], t.lo[63:61]};
    return r;
  endfunction

endpackage

### rtl/core/p128_cfg_if.sv
interface p128_cfg_if import p128_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BLOCK_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/p128_in_if.sv
interface p128_in_if import p128_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [BLOCK_W-1:0] block_in;

  modport source(output valid, mode, block_in, input ready);
  modport sink(input valid, mode, block_in, output ready);
endinterface

### rtl/core/p128_out_if.sv
interface p128_out_if import p128_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BLOCK_W-1:0] block_out;

  modport source(output valid, block_out, input ready);
  modport sink(input valid, block_out, output ready);
endinterface

### rtl/core/present128_block_cipher.sv
// PRESENT block cipher with a 128-bit key, one round per clock on a single shared
// round unit and a single key schedule unit that steps the round key alongside it.
// A block (mode 0 encrypts, mode 1 decrypts) is taken only while the core is idle
// and its result is registered once its last round is done; the last round folds
// in the final whitening and the core is idle again from the cycle the result
// appears, so blocks are taken one at a time, each once the one before is done.
// The result waits in an output register until taken; the next block runs
// meanwhile, but its last round holds until the waiting result is taken. Round
// keys are produced on the fly: encryption steps forward from the key registers,
// decryption steps backward from the last round key, which is held in a register.
// After reset and after every write to key_high (index 0) or key_low (index 1) the
// core runs a key pass that steps forward to find that last key; blocks are not
// taken during the pass, while further key writes are taken and restart it.
// Writes to other indexes are ignored.
`include "present128_block_cipher_macros.svh"

module present128_block_cipher import p128_pkg::*; #(
  parameter int unsigned ROUND_KEYS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  p128_cfg_if.sink    cfg_i,
  p128_in_if.sink     in_i,
  p128_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(ROUND_KEYS);
  localparam logic [CntW-1:0] FirstCnt = CntW'(1);
  localparam logic [CntW-1:0] LastCnt  = CntW'(ROUND_KEYS - 1);

  localparam logic [1:0] ST_DERIVE = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [BLOCK_W-1:0] key_high_q, key_high_d;
  logic [BLOCK_W-1:0] key_low_q, key_low_d;
  key128_t            wk_q, wk_d;
  key128_t            fin_q, fin_d;
  logic [BLOCK_W-1:0] s_q, s_d;
  logic               mode_q, mode_d;
  logic [BLOCK_W-1:0] block_out_q, block_out_d;
  logic               out_valid_q, out_valid_d;

  logic               cfg_fire, cfg_hit, in_fire, out_fire, last_round;
  logic [4:0]         cnt5;
  key128_t            key_nxt;
  logic [BLOCK_W-1:0] rnd_in, rnd_out;

  assign cfg_i.ready   = (state_q == ST_DERIVE) || (state_q == ST_IDLE);
  assign in_i.ready    = (state_q == ST_IDLE) && !cfg_i.valid;
  assign out_o.valid   = out_valid_q;
  assign out_o.block_out = block_out_q;

  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign cfg_hit  = cfg_fire &&
                    (cfg_i.index == KEY_HIGH_IDX || cfg_i.index == KEY_LOW_IDX);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  // Shared key schedule unit: backward only while decrypting.
  assign cnt5    = 5'(cnt_q);
  assign key_nxt = (state_q == ST_RUN && mode_q) ? key_step_inv(wk_q, cnt5)
                                                 : key_step_fwd(wk_q, cnt5);

  // Shared round unit.
  assign rnd_in  = s_q ^ wk_q.hi;
  assign rnd_out = mode_q ? sub_inv(perm_inv(rnd_in)) : perm_fwd(sub_fwd(rnd_in));

  assign last_round = mode_q ? (cnt_q == FirstCnt) : (cnt_q == LastCnt);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    key_high_d  = key_high_q;
    key_low_d   = key_low_q;
    wk_d        = wk_q;
    fin_d       = fin_q;
    s_d         = s_q;
    mode_d      = mode_q;
    block_out_d = block_out_q;
    out_valid_d = out_valid_q;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_DERIVE: begin
        wk_d  = key_nxt;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastCnt) begin
          fin_d   = key_nxt;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          s_d     = in_i.block_in;
          mode_d  = in_i.mode;
          state_d = ST_RUN;
          if (in_i.mode) begin
            wk_d  = fin_q;
            cnt_d = LastCnt;
          end else begin
            wk_d.hi = key_high_q;
            wk_d.lo = key_low_q;
            cnt_d   = FirstCnt;
          end
        end
      end
      ST_RUN: begin
        // hold the last round while the previous result still waits
        if (!last_round || !out_valid_q || out_fire) begin
          s_d   = rnd_out;
          wk_d  = key_nxt;
          cnt_d = mode_q ? cnt_q - CntW'(1) : cnt_q + CntW'(1);
          if (last_round) begin
            // fold in the whitening key
            block_out_d = rnd_out ^ key_nxt.hi;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A key write restarts the key pass from the new key.
    if (cfg_hit) begin
      if (cfg_i.index == KEY_HIGH_IDX) begin
        key_high_d = cfg_i.data;
      end else begin
        key_low_d = cfg_i.data;
      end
      wk_d.hi = key_high_d;
      wk_d.lo = key_low_d;
      cnt_d   = FirstCnt;
      state_d = ST_DERIVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DERIVE;
      cnt_q       <= FirstCnt;
      key_high_q  <= '0;
      key_low_q   <= '0;
      wk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      key_high_q  <= key_high_d;
      key_low_q   <= key_low_d;
      wk_q        <= wk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q       <= fin_d;
    s_q         <= s_d;
    mode_q      <= mode_d;
    block_out_q <= block_out_d;
  end

  `P128_ASSERT(a_accept_starts_run, clk_i, rst_ni, in_fire |=> (state_q == ST_RUN))
  `P128_ASSERT(a_key_write_derives, clk_i, rst_ni, cfg_hit |=> (state_q == ST_DERIVE))
  `P128_ASSERT(a_cnt_nonzero, clk_i, rst_ni,
    (state_q == ST_RUN || state_q == ST_DERIVE) |-> (cnt_q != '0))
  `P128_ASSERT(a_out_held, clk_i, rst_ni,
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.block_out)))
  `P128_ASSERT_ALWAYS(a_ready_only_idle, clk_i, !in_i.ready || (state_q == ST_IDLE))

endmodule
